FILE: hdl/median_3x3_rgba_filter_defines.svh
// Assertion macros shared by the median filter RTL.
`ifndef MEDIAN_3X3_RGBA_FILTER_DEFINES_SVH
`define MEDIAN_3X3_RGBA_FILTER_DEFINES_SVH
`ifndef SYNTH
`define MF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MF_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define MF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/mf_pkg.sv
package mf_pkg;
   localparam int MAX_WIDTH = 2048;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int WREG_W    = 12;
   localparam int HREG_W    = 16;
   localparam int ROW_W     = 17;
   localparam int CH_W      = 8;
   localparam int PIX_W     = 4 * CH_W;
   localparam int TAPS      = 9;
   localparam int MED_IDX   = 4;
   localparam int NUM_LANES = 3;
   localparam int NET_LEN   = 19;

   // Compare-exchange pairs of the nine-input median network.
   localparam logic [3:0] NET_A [NET_LEN] =
      '{4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
        4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4};
   localparam logic [3:0] NET_B [NET_LEN] =
      '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
        4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2};

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [TAPS-1:0][CH_W-1:0] taps_type;

   typedef struct packed {
      logic                            last;
      logic [CH_W-1:0]                 alpha;
      taps_type [NUM_LANES-1:0]        lanes;
   } win_type;
endpackage

FILE: hdl/median_3x3_rgba_filter.sv
// 3x3 median filter for RGBA pixel streams in raster order. Red, green and blue
// of each result are the medians of the pixel's 3x3 neighbourhood on that
// channel, with pixels outside the image read as zero; alpha is the centre
// pixel's. A frame of W x H pixels must be followed by W+1 drain requests
// (req_tuser high) that act as the bottom zero row; the result for the last
// pixel is marked with rsp_tlast. The block takes one request per clock cycle
// unless held by rsp_tready or line store clearing, and gives results in the
// same order, each following the request completing its neighbourhood (one
// row and one pixel later) through stage one, stage two and the output register.
// After reset both line stores are cleared one entry per cycle, refusing requests.
// Width and height may only be written while no results are outstanding.
module median_3x3_rgba_filter
   import mf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // red_in, green_in, blue_in, alpha_in
   input  logic        req_tuser,  // operation (drain request when high)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // red_out, green_out, blue_out, alpha_out
   output logic        rsp_tlast,  // end_of_frame
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);
   `include "median_3x3_rgba_filter_defines.svh"

   logic [WREG_W-1:0] width_ff, width_eff;
   logic [HREG_W-1:0] height_ff, height_eff;
   logic              win_valid, win_ready;
   win_type           win;
   logic [CH_W-1:0]   med [NUM_LANES];
   logic              out_v_ff;
   logic [PIX_W-1:0]  out_data_ff;
   logic              out_last_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WREG_W'(MAX_WIDTH);
         height_ff <= HREG_W'(1);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_WIDTH:  width_ff  <= csr_data[WREG_W-1:0];
            CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // A zero width or height is taken as one; a width beyond the store is clamped.
   assign width_eff  = (width_ff == '0) ? WREG_W'(1) :
                       (width_ff > WREG_W'(MAX_WIDTH)) ? WREG_W'(MAX_WIDTH) : width_ff;
   assign height_eff = (height_ff == '0) ? HREG_W'(1) : height_ff;

   mf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_drain   (req_tuser),
      .in_pix     (req_tdata),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .win_valid  (win_valid),
      .win_ready  (win_ready),
      .win        (win)
   );

   // One sorting lane per colour channel, running side by side.
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      mf_median_lane u_lane (
         .taps   (win.lanes[l]),
         .median (med[l])
      );
   end

   // The output register merges the lane medians with alpha and the frame flag.
   assign win_ready = !out_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (win_ready) begin
         out_v_ff <= win_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (win_ready) begin
         out_data_ff <= {win.alpha, med[2], med[1], med[0]};
         out_last_ff <= win.last;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   `MF_ASSERT_NEXT(a_window_reaches_output, clock, reset, win_valid && win_ready, rsp_tvalid)
endmodule

FILE: hdl/mf_median_lane.sv
module mf_median_lane
   import mf_pkg::*;
(
   input  taps_type        taps,
   output logic [CH_W-1:0] median
);
   logic [CH_W-1:0] work [TAPS];
   logic [CH_W-1:0] lo;
   logic [CH_W-1:0] hi;

   // Fixed compare-exchange network; after it the middle slot holds the median.
   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         work[i] = taps[i];
      end
      for (int k = 0; k < NET_LEN; k++) begin
         lo = (work[NET_A[k]] > work[NET_B[k]]) ? work[NET_B[k]] : work[NET_A[k]];
         hi = (work[NET_A[k]] > work[NET_B[k]]) ? work[NET_A[k]] : work[NET_B[k]];
         work[NET_A[k]] = lo;
         work[NET_B[k]] = hi;
      end
   end

   assign median = work[MED_IDX];
endmodule

FILE: hdl/mf_front.sv
module mf_front
   import mf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_drain,
   input  logic [PIX_W-1:0]  in_pix,
   input  logic [WREG_W-1:0] width_eff,
   input  logic [HREG_W-1:0] height_eff,
   output logic              win_valid,
   input  logic              win_ready,
   output win_type           win
);
   `include "median_3x3_rgba_filter_defines.svh"

   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   logic              clearing_ff;
   logic [ADDR_W:0]   clr_cnt_ff;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   logic              s1_v_ff, s1_e0_ff, s1_e1_ff, s1_r1_ff, s1_r2_ff;
   logic              s1_c1_ff, s1_w2_ff, s1_last_ff, s1_byp_ff;
   logic [ADDR_W-1:0] s1_c_ff;
   logic [PIX_W-1:0]  s1_pix_ff, s1_byp_up_ff, s1_byp_md_ff, up_q_ff, md_q_ff;
   logic [PIX_W-1:0]  wc_ff [TAPS];
   logic              s2_v_ff;
   win_type           s2_ff, s2_in;

   logic [ROW_W:0]    r, hp1;
   logic [WREG_W:0]   cn;
   logic [ADDR_W-1:0] c;
   logic [PIX_W-1:0]  pix, up_g, md_g;
   logic              e0, e1, last, acc, s1_adv, byp;
   logic [PIX_W-1:0]  tmp [TAPS];

   assign s1_adv    = !s2_v_ff || win_ready;
   assign in_ready  = !clearing_ff && (!s1_v_ff || s1_adv);
   assign acc       = in_valid && in_ready;
   assign win_valid = s2_v_ff;
   assign win       = s2_ff;

   // Stream position of the incoming item, normalised as the frame rules demand.
   always_comb begin
      r = {1'b0, row_ff};
      c = col_ff;
      if ({1'b0, col_ff} >= width_eff) begin
         c = '0;
         r = r + 1'b1;
      end
      hp1 = {{(ROW_W + 1 - HREG_W){1'b0}}, height_eff} + 1'b1;
      if (r > hp1 || (r == hp1 && c != '0)) begin
         r = '0;
         c = '0;
      end
      pix  = (r < {2'b0, height_eff} && !in_drain) ? in_pix : '0;
      e0   = (c == '0) && (r >= 2);
      e1   = (c != '0) && (r >= 1) && (r <= {2'b0, height_eff});
      last = e0 && (r == hp1);
      byp  = s1_v_ff && (s1_c_ff == c);
      cn   = {2'b0, c} + 1'b1;
      if (last) begin
         col_in = '0;
         row_in = '0;
      end else if (cn >= {1'b0, width_eff}) begin
         col_in = '0;
         row_in = ROW_W'(r + 1'b1);
      end else begin
         col_in = cn[ADDR_W-1:0];
         row_in = r[ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         for (int i = 0; i < TAPS; i++) begin
            wc_ff[i] <= '0;
         end
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == (ADDR_W + 1)'(MAX_WIDTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (acc) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (!s1_v_ff || s1_adv) begin
            s1_v_ff <= acc;
         end
         if (s1_adv) begin
            s2_v_ff <= s1_v_ff && (s1_e0_ff || s1_e1_ff);
            if (s1_v_ff) begin
               for (int i = 0; i < 6; i++) begin
                  wc_ff[i] <= wc_ff[i + 3];
               end
               wc_ff[6] <= up_g;
               wc_ff[7] <= md_g;
               wc_ff[8] <= s1_pix_ff;
            end
         end
      end
   end

   // Stage one payload, with the line store read registered on acceptance.
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_c_ff      <= c;
         s1_e0_ff     <= e0;
         s1_e1_ff     <= e1;
         s1_r1_ff     <= r >= 1;
         s1_r2_ff     <= r >= 2;
         s1_c1_ff     <= c == ADDR_W'(1);
         s1_w2_ff     <= width_eff >= WREG_W'(2);
         s1_last_ff   <= last;
         s1_pix_ff    <= pix;
         s1_byp_ff    <= byp;
         s1_byp_up_ff <= md_g;
         s1_byp_md_ff <= s1_pix_ff;
         up_q_ff      <= upper_mem[c];
         md_q_ff      <= middle_mem[c];
      end
      if (s1_adv) begin
         s2_ff <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         upper_mem[clr_cnt_ff[ADDR_W-1:0]]  <= '0;
         middle_mem[clr_cnt_ff[ADDR_W-1:0]] <= '0;
      end else if (s1_v_ff && s1_adv) begin
         upper_mem[s1_c_ff]  <= md_g;
         middle_mem[s1_c_ff] <= s1_pix_ff;
      end
   end

   // A result is taken either from the border window of the previous row or
   // from the freshly shifted window.
   always_comb begin
      up_g = s1_r2_ff ? (s1_byp_ff ? s1_byp_up_ff : up_q_ff) : '0;
      md_g = s1_r1_ff ? (s1_byp_ff ? s1_byp_md_ff : md_q_ff) : '0;
      for (int i = 0; i < 3; i++) begin
         if (s1_e0_ff) begin
            tmp[i]     = s1_w2_ff ? wc_ff[3 + i] : '0;
            tmp[3 + i] = wc_ff[6 + i];
            tmp[6 + i] = '0;
         end else begin
            tmp[i]     = s1_c1_ff ? '0 : wc_ff[3 + i];
            tmp[3 + i] = wc_ff[6 + i];
            tmp[6 + i] = '0;
         end
      end
      if (!s1_e0_ff) begin
         tmp[6] = up_g;
         tmp[7] = md_g;
         tmp[8] = s1_pix_ff;
      end
      s2_in.last  = s1_last_ff;
      s2_in.alpha = tmp[MED_IDX][4*CH_W-1 -: CH_W];
      for (int l = 0; l < NUM_LANES; l++) begin
         for (int t = 0; t < TAPS; t++) begin
            s2_in.lanes[l][t] = tmp[t][l*CH_W +: CH_W];
         end
      end
   end

   `MF_ASSERT_SAME(a_no_accept_clearing, clock, reset, clearing_ff, !in_ready)
   `MF_ASSERT_NEXT(a_accept_fills_s1, clock, reset, acc, s1_v_ff)
endmodule
